/* hw/rtl/bf3_pkg.sv */
// ----------------------------------------------------------------------------
// bf3_pkg: shared definitions for the 3x3 box filter
// Widths, register indexes and the pixel position record that passes from
// the frame counters to the pipeline.
// ----------------------------------------------------------------------------
package bf3_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int PIX_W       = 16;
	localparam int SUM_W       = 20;
	localparam int WIDTH_W     = 11;
	localparam int HEIGHT_W    = 16;
	localparam int CFG_W       = 16;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = HEIGHT_W;
	localparam int EFF_W       = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1024);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1024);

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic             emit;
		logic             last_col;
		logic             last_row;
	} pos_t;

endpackage

/* hw/rtl/bf3_ctrl.sv */
// ----------------------------------------------------------------------------
// bf3_ctrl: configuration registers and frame position counters
// Holds image width and height, clamps them to their legal ranges and tracks
// the column and row of the next pixel to be transferred.
// ----------------------------------------------------------------------------
module bf3_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [bf3_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        advance,
	output bf3_pkg::pos_t               pos
);

	logic [bf3_pkg::WIDTH_W-1:0]  image_width_q;
	logic [bf3_pkg::HEIGHT_W-1:0] image_height_q;
	logic [bf3_pkg::COL_W-1:0]    col_q;
	logic [bf3_pkg::ROW_W-1:0]    row_q;

	logic [bf3_pkg::EFF_W-1:0]    w_raw;
	logic [bf3_pkg::EFF_W-1:0]    w_eff;
	logic [bf3_pkg::EFF_W-1:0]    last_col_pos;
	logic [bf3_pkg::EFF_W-1:0]    col_ext;
	logic [bf3_pkg::EFF_W-1:0]    col_clamp;
	logic [bf3_pkg::HEIGHT_W-1:0] h_eff;
	logic [bf3_pkg::HEIGHT_W-1:0] last_row_pos;
	logic [bf3_pkg::ROW_W-1:0]    row_clamp;

	always_comb begin
		w_raw = bf3_pkg::EFF_W'(image_width_q);
		if (w_raw < bf3_pkg::EFF_W'(3)) begin
			w_eff = bf3_pkg::EFF_W'(3);
		end else if (w_raw > bf3_pkg::EFF_W'(bf3_pkg::MAX_WIDTH)) begin
			w_eff = bf3_pkg::EFF_W'(bf3_pkg::MAX_WIDTH);
		end else begin
			w_eff = w_raw;
		end
		last_col_pos = w_eff - bf3_pkg::EFF_W'(1);
		col_ext = bf3_pkg::EFF_W'(col_q);
		col_clamp = (col_ext >= last_col_pos) ? last_col_pos : col_ext;

		h_eff = (image_height_q < bf3_pkg::HEIGHT_W'(3)) ? bf3_pkg::HEIGHT_W'(3)
			: image_height_q;
		last_row_pos = h_eff - bf3_pkg::HEIGHT_W'(1);
		row_clamp = (row_q >= last_row_pos) ? last_row_pos : row_q;

		pos.col = col_clamp[bf3_pkg::COL_W-1:0];
		pos.last_col = (col_clamp == last_col_pos);
		pos.last_row = (row_clamp == last_row_pos);
		pos.emit = (row_clamp >= bf3_pkg::ROW_W'(2)) && (col_clamp >= bf3_pkg::EFF_W'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= bf3_pkg::WIDTH_RESET;
			image_height_q <= bf3_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bf3_pkg::REG_IMAGE_WIDTH: image_width_q <= cfg_data[bf3_pkg::WIDTH_W-1:0];
				bf3_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data[bf3_pkg::HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (pos.last_col) begin
				col_q <= '0;
				row_q <= pos.last_row ? '0 : row_clamp + bf3_pkg::ROW_W'(1);
			end else begin
				col_q <= pos.col + bf3_pkg::COL_W'(1);
				row_q <= row_clamp;
			end
		end
	end

endmodule

/* hw/rtl/bf3_line_buf.sv */
// ----------------------------------------------------------------------------
// bf3_line_buf: two line buffers for the rows above the current one
// One registered read of both rows per transfer, and one write of both rows
// when the pixel leaves the first pipeline stage.
// ----------------------------------------------------------------------------
module bf3_line_buf (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [bf3_pkg::COL_W-1:0]  rd_addr,
	output logic [bf3_pkg::PIX_W-1:0]  rd_upper,
	output logic [bf3_pkg::PIX_W-1:0]  rd_middle,
	input  logic                       wr_en,
	input  logic [bf3_pkg::COL_W-1:0]  wr_addr,
	input  logic [bf3_pkg::PIX_W-1:0]  wr_upper,
	input  logic [bf3_pkg::PIX_W-1:0]  wr_middle
);

	logic [bf3_pkg::PIX_W-1:0] upper_mem [bf3_pkg::MAX_WIDTH];
	logic [bf3_pkg::PIX_W-1:0] middle_mem [bf3_pkg::MAX_WIDTH];
	logic [bf3_pkg::PIX_W-1:0] rd_upper_q;
	logic [bf3_pkg::PIX_W-1:0] rd_middle_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[wr_addr] <= wr_upper;
			middle_mem[wr_addr] <= wr_middle;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_upper_q <= upper_mem[rd_addr];
			rd_middle_q <= middle_mem[rd_addr];
		end
	end

	assign rd_upper = rd_upper_q;
	assign rd_middle = rd_middle_q;

endmodule

/* hw/rtl/bf3_window.sv */
// ----------------------------------------------------------------------------
// bf3_window: 3x3 window columns and neighbourhood adder
// Keeps the two columns left of the current one and adds them to the
// current column to form the nine-pixel sum.
// ----------------------------------------------------------------------------
module bf3_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       shift,
	input  logic [bf3_pkg::PIX_W-1:0]  top,
	input  logic [bf3_pkg::PIX_W-1:0]  mid,
	input  logic [bf3_pkg::PIX_W-1:0]  bot,
	output logic [bf3_pkg::SUM_W-1:0]  sum
);

	logic [bf3_pkg::PIX_W-1:0] c1_q [3];
	logic [bf3_pkg::PIX_W-1:0] c2_q [3];
	logic [bf3_pkg::SUM_W-1:0] col0_sum;
	logic [bf3_pkg::SUM_W-1:0] col1_sum;
	logic [bf3_pkg::SUM_W-1:0] col2_sum;

	always_comb begin
		col0_sum = bf3_pkg::SUM_W'(top) + bf3_pkg::SUM_W'(mid) + bf3_pkg::SUM_W'(bot);
		col1_sum = bf3_pkg::SUM_W'(c1_q[0]) + bf3_pkg::SUM_W'(c1_q[1])
			+ bf3_pkg::SUM_W'(c1_q[2]);
		col2_sum = bf3_pkg::SUM_W'(c2_q[0]) + bf3_pkg::SUM_W'(c2_q[1])
			+ bf3_pkg::SUM_W'(c2_q[2]);
		sum = col0_sum + col1_sum + col2_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				c1_q[i] <= '0;
				c2_q[i] <= '0;
			end
		end else if (shift) begin
			c2_q <= c1_q;
			c1_q[0] <= top;
			c1_q[1] <= mid;
			c1_q[2] <= bot;
		end
	end

endmodule

/* hw/rtl/box_filter_3x3_valid.sv */
// ----------------------------------------------------------------------------
// box_filter_3x3_valid: streaming 3x3 box filter, valid mode
// Sums each 3x3 neighbourhood of a raster-order pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on the input channel (in_valid, in_ready, pixel) in raster
// order. For every pixel at row two or later and column two or later, one
// result leaves on the output channel (out_valid, out_ready, box_sum,
// row_end, frame_end), giving a (width-2) by (height-2) output frame.
// row_end marks the last result of an output row, frame_end the last result
// of the frame. Other pixels are consumed and give no result.
// While the output is not stalled, a pixel is transferred every cycle: the
// line buffer read takes place at the input transfer, the sum is formed in the
// following stage, and a result is loaded into the output register when its
// pixel leaves the first stage. The single line buffer read port per pixel
// sets the rate at one pixel a cycle.
// If the receiver stalls, the output register holds its result and pixels
// that give no result keep flowing; the next pixel that gives a result is
// held in the first stage, and then in_ready falls.
// Reset clears the counters and the window and sets width and height to
// 1024; line buffer contents are not cleared, as an entry is written before
// its value can reach a result. Width and height are written through cfg_we,
// cfg_index and cfg_data by the user while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module box_filter_3x3_valid (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [bf3_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [bf3_pkg::PIX_W-1:0]  pixel,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [bf3_pkg::SUM_W-1:0]  box_sum,
	output logic                       row_end,
	output logic                       frame_end
);

	bf3_pkg::pos_t              pos;
	bf3_pkg::pos_t              pos_s1;
	logic                       valid_s1;
	logic [bf3_pkg::PIX_W-1:0]  pixel_s1;
	logic [bf3_pkg::PIX_W-1:0]  rd_upper;
	logic [bf3_pkg::PIX_W-1:0]  rd_middle;
	logic [bf3_pkg::SUM_W-1:0]  sum;
	logic                       accept;
	logic                       out_free;
	logic                       s1_adv;
	logic                       out_valid_q;
	logic [bf3_pkg::SUM_W-1:0]  box_sum_q;
	logic                       row_end_q;
	logic                       frame_end_q;

	assign out_free = !out_valid_q || out_ready;
	assign s1_adv = valid_s1 && (!pos_s1.emit || out_free);
	assign in_ready = !valid_s1 || s1_adv;
	assign accept = in_valid && in_ready;

	bf3_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (accept),
		.pos       (pos)
	);

	bf3_line_buf u_line_buf (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr   (pos.col),
		.rd_upper  (rd_upper),
		.rd_middle (rd_middle),
		.wr_en     (s1_adv),
		.wr_addr   (pos_s1.col),
		.wr_upper  (rd_middle),
		.wr_middle (pixel_s1)
	);

	bf3_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (s1_adv),
		.top    (rd_upper),
		.mid    (rd_middle),
		.bot    (pixel_s1),
		.sum    (sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixel;
			pos_s1 <= pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && pos_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && pos_s1.emit) begin
			box_sum_q <= sum;
			row_end_q <= pos_s1.last_col;
			frame_end_q <= pos_s1.last_col && pos_s1.last_row;
		end
	end

	assign out_valid = out_valid_q;
	assign box_sum = box_sum_q;
	assign row_end = row_end_q;
	assign frame_end = frame_end_q;

	// A pending first-stage pixel that cannot move must keep its position.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1 && $stable(pos_s1) && $stable(pixel_s1))
		else $error("first stage changed while stalled");

	// The last result of a frame is always the last result of a row.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> row_end)
		else $error("frame end without row end");

	// Back-pressure at the input only comes from a held first stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && pos_s1.emit && out_valid_q && !out_ready)
		else $error("input stalled without cause");

	// Results are only loaded from pixels that carry an emit mark.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q && !(s1_adv && pos_s1.emit) |=> !out_valid_q)
		else $error("result appeared without a source pixel");

endmodule
